[hw/rtl/asp_pkg.sv]
// Shared constants, widths and control types for the appliance subset power match block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package asp_pkg;

   // Field widths.
   localparam int POWER_W = 20;
   localparam int MEAS_W  = 23;
   localparam int MASK_W  = 7;

   // Adder tree widths over eight lanes: pairs, quads and the full sum.
   localparam int LANES  = 8;
   localparam int PAIR_W = POWER_W + 1;
   localparam int QUAD_W = POWER_W + 2;
   localparam int SUM_W  = POWER_W + 3;

   // Register file layout.
   localparam int REG_COUNT  = 8;
   localparam int IDX_W      = 3;
   localparam int POWER_REGS = 7;
   localparam logic [IDX_W-1:0] REG_TOLERANCE = 3'd7;

   // Register reset values.
   localparam logic [POWER_W-1:0] APPLIANCE_1_RESET = 20'd22372;
   localparam logic [POWER_W-1:0] TOLERANCE_RESET   = 20'd500;

   // Default appliance count.
   localparam int NUM_APPLIANCES_DEFAULT = 7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic flush;
      logic issue;
      logic capture;
      logic publish;
   } dp_cmd_type;

   // Status from the end of the datapath pipeline.
   typedef struct packed {
      logic hit;
      logic last_done;
   } dp_status_type;

endpackage

`default_nettype wire

[hw/rtl/asp_if.sv]
// Valid/ready channel interfaces for measurement requests and match responses.
// Depends on asp_pkg for the field widths.
`default_nettype none

interface asp_req_if;
   logic                         valid;
   logic                         ready;
   logic [asp_pkg::MEAS_W-1:0]   measured_power;

   modport source (output valid, output measured_power, input ready);
   modport sink   (input valid, input measured_power, output ready);
endinterface

interface asp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [asp_pkg::MASK_W-1:0]   on_mask;
   logic                         found;

   modport source (output valid, output on_mask, output found, input ready);
   modport sink   (input valid, input on_mask, input found, output ready);
endinterface

`default_nettype wire

[hw/rtl/appliance_subset_power_match.sv]
// Top level of the appliance subset power match block: joins the controller and the datapath.
// Depends on asp_pkg, asp_if (channel interfaces), asp_ctrl and asp_dp.
//
//   Channel  | Direction | Payload                         | Handshake
//   req_bus  | in        | measured_power[22:0]            | valid / ready
//   rsp_bus  | out       | on_mask[6:0], found             | valid / ready
//   csr_*    | in        | csr_index[2:0], csr_write_data  | csr_write_enable, no stall
//
// One measurement is searched at a time, one combination per cycle through a
// four-stage adder tree and compare. The search ends at the first matching
// combination, or once all 2^NUM_APPLIANCES combinations have passed with no
// match. The output register lets the next beat be taken while a result waits;
// a stalled result delays only the publish of the following one. Reset is
// synchronous and restores register defaults.
`default_nettype none

module appliance_subset_power_match #(
   parameter int NUM_APPLIANCES = asp_pkg::NUM_APPLIANCES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   asp_req_if.sink                            req_bus,
   asp_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_write_enable,
   input  wire logic [asp_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [asp_pkg::POWER_W-1:0]   csr_write_data
);

   asp_pkg::dp_cmd_type       cmd;
   asp_pkg::dp_status_type    status;
   logic [NUM_APPLIANCES-1:0] combo;

   // Sequencing.
   asp_ctrl #(
      .NUM_APPLIANCES (NUM_APPLIANCES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd),
      .combo     (combo)
   );

   // Arithmetic and registers.
   asp_dp #(
      .NUM_APPLIANCES (NUM_APPLIANCES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .measured_power   (req_bus.measured_power),
      .cmd              (cmd),
      .combo            (combo),
      .status           (status),
      .on_mask          (rsp_bus.on_mask),
      .found            (rsp_bus.found)
   );

endmodule

`default_nettype wire

[hw/rtl/asp_ctrl.sv]
// Controller state machine: walks the combination counter and sequences load, search,
// capture and publish. Depends on asp_pkg for command and status types.
`default_nettype none

module asp_ctrl #(
   parameter int NUM_APPLIANCES = asp_pkg::NUM_APPLIANCES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire asp_pkg::dp_status_type        status,
   output asp_pkg::dp_cmd_type                cmd,
   output logic [NUM_APPLIANCES-1:0]          combo
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_PUB   = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [NUM_APPLIANCES-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Next-state and command decode.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.flush = 1'b1;
               cnt_in    = '0;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            // A hit ends the search at once; later combinations are discarded.
            if (status.hit) begin
               cmd.capture = 1'b1;
               cmd.flush   = 1'b1;
               state_in    = S_PUB;
            end else begin
               cmd.issue = 1'b1;
               if (cnt_ff == '1) begin
                  state_in = S_DRAIN;
               end else begin
                  cnt_in = NUM_APPLIANCES'(cnt_ff + 1'b1);
               end
            end
         end
         S_DRAIN: begin
            if (status.hit || status.last_done) begin
               cmd.capture = 1'b1;
               cmd.flush   = 1'b1;
               state_in    = S_PUB;
            end
         end
         S_PUB: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign combo     = cnt_ff;

endmodule

`default_nettype wire

[hw/rtl/asp_dp.sv]
// Datapath: configuration registers, a registered adder tree over the appliance lanes,
// the tolerance compare and the result and output registers. Depends on asp_pkg.
`default_nettype none

module asp_dp #(
   parameter int NUM_APPLIANCES = asp_pkg::NUM_APPLIANCES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [asp_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [asp_pkg::POWER_W-1:0]   csr_write_data,
   input  wire logic [asp_pkg::MEAS_W-1:0]    measured_power,
   input  wire asp_pkg::dp_cmd_type           cmd,
   input  wire logic [NUM_APPLIANCES-1:0]     combo,
   output asp_pkg::dp_status_type             status,
   output logic [asp_pkg::MASK_W-1:0]         on_mask,
   output logic                               found
);

   localparam int PowerW = asp_pkg::POWER_W;
   localparam int PairW  = asp_pkg::PAIR_W;
   localparam int QuadW  = asp_pkg::QUAD_W;
   localparam int SumW   = asp_pkg::SUM_W;
   localparam int MaskW  = asp_pkg::MASK_W;
   localparam int Lanes  = asp_pkg::LANES;
   localparam int PowerRegs = asp_pkg::POWER_REGS;

   logic [PowerW-1:0] power_ff [PowerRegs];
   logic [PowerW-1:0] tol_ff;
   logic [SumW-1:0]   meas_ff;

   // Configuration registers; the tolerance sits at the last index.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PowerRegs; k++) begin
            power_ff[k] <= (k == 0) ? asp_pkg::APPLIANCE_1_RESET : '0;
         end
         tol_ff      <= asp_pkg::TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == asp_pkg::REG_TOLERANCE) begin
            tol_ff <= csr_write_data;
         end else begin
            power_ff[csr_index] <= csr_write_data;
         end
      end
   end

   // Measurement latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff <= measured_power;
      end
   end

   // Lane selection: an appliance contributes its power when its combination bit is set.
   logic [PowerW-1:0] lane_val [Lanes];
   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      if (k < NUM_APPLIANCES && k < PowerRegs) begin : g_on
         assign lane_val[k] = combo[k] ? power_ff[k] : '0;
      end else begin : g_off
         assign lane_val[k] = '0;
      end
   end

   // Pipeline valid bits and combination tags.
   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic [NUM_APPLIANCES-1:0] c1_ff, c2_ff, c3_ff, c4_ff;
   logic [PairW-1:0]          pair_ff [Lanes/2];
   logic [QuadW-1:0]          quad_ff [Lanes/4];
   logic [SumW-1:0]           sum_ff;
   logic                      hit4_ff;
   logic [SumW-1:0]           diff;
   logic                      hit3;

   // The flush clears every stage; it also overrides a same-cycle issue.
   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Adder tree stages, one level per register.
   always_ff @(posedge clock) begin
      for (int j = 0; j < Lanes / 2; j++) begin
         pair_ff[j] <= PairW'(lane_val[2*j]) + PairW'(lane_val[2*j+1]);
      end
      for (int j = 0; j < Lanes / 4; j++) begin
         quad_ff[j] <= QuadW'(pair_ff[2*j]) + QuadW'(pair_ff[2*j+1]);
      end
      sum_ff <= SumW'(quad_ff[0]) + SumW'(quad_ff[1]);
      c1_ff  <= combo;
      c2_ff  <= c1_ff;
      c3_ff  <= c2_ff;
      c4_ff  <= c3_ff;
   end

   // Absolute difference against the measurement, compared with the tolerance.
   always_comb begin
      if (sum_ff >= meas_ff) begin
         diff = sum_ff - meas_ff;
      end else begin
         diff = meas_ff - sum_ff;
      end
      hit3 = (diff < SumW'(tol_ff));
   end

   always_ff @(posedge clock) begin
      hit4_ff <= hit3;
   end

   assign status.hit       = v4_ff && hit4_ff;
   assign status.last_done = v4_ff && (c4_ff == '1);

   // Result holding register, then the output register.
   logic             res_found_ff;
   logic [MaskW-1:0] res_mask_ff;
   logic             out_found_ff;
   logic [MaskW-1:0] out_mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_found_ff <= status.hit;
         res_mask_ff  <= status.hit ? MaskW'(c4_ff) : '0;
      end
      if (cmd.publish) begin
         out_found_ff <= res_found_ff;
         out_mask_ff  <= res_mask_ff;
      end
   end

   assign on_mask = out_mask_ff;
   assign found   = out_found_ff;

endmodule

`default_nettype wire

[hw/rtl/asp_chk.sv]
// Port-level checker for the appliance subset power match block, bound to the top level.
// Depends only on the top level's ports and on asp_pkg for widths.
`default_nettype none

module asp_chk (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [asp_pkg::MASK_W-1:0]    rsp_on_mask,
   input wire logic                          rsp_found
);

   // Beats accepted but not yet delivered.
   logic [2:0] pending_ff;
   logic [2:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = 3'(pending_in + 3'd1);
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = 3'(pending_in - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A presented result is held until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_on_mask) && $stable(rsp_found))
      else $error("response dropped or changed while stalled");

   // No match always reports an empty mask.
   a_miss_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_on_mask == '0)
      else $error("mask set without a match");

   // Every response answers an accepted request.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding request");

   // At most one beat in search and one in the output register.
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("too many beats in flight");

   // Nothing is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind appliance_subset_power_match asp_chk u_asp_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_on_mask (rsp_bus.on_mask),
   .rsp_found   (rsp_bus.found)
);

`default_nettype wire

[tb/sv/appliance_subset_power_match_test.sv]
// Self-checking testbench for the appliance subset power match block.
// Depends on asp_pkg, the asp_req_if / asp_rsp_if channel interfaces and the block's top level.
// Results are predicted by an in-bench exhaustive combination search and compared in order.
`timescale 1ns / 1ps

module appliance_subset_power_match_test;

   localparam int POWER_W        = asp_pkg::POWER_W;
   localparam int MEAS_W         = asp_pkg::MEAS_W;
   localparam int MASK_W         = asp_pkg::MASK_W;
   localparam int SUM_W          = asp_pkg::SUM_W;
   localparam int IDX_W          = asp_pkg::IDX_W;
   localparam int POWER_REGS     = asp_pkg::POWER_REGS;
   localparam int NUM_APPLIANCES = asp_pkg::NUM_APPLIANCES_DEFAULT;
   localparam int POWER_MAX      = (1 << POWER_W) - 1;
   localparam int MEAS_MAX       = (1 << MEAS_W) - 1;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 2 * ((1 << NUM_APPLIANCES) + 6);
   localparam int PHASE_BEATS    = 145;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [MASK_W-1:0] on_mask;
      logic              found;
   } match_result_type;

   typedef enum int {
      STYLE_WIDE,
      STYLE_SMALL,
      STYLE_BINARY,
      STYLE_SATURATED,
      STYLE_LOOSE,
      STYLE_SPARSE
   } settings_style_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [IDX_W-1:0]     csr_index;
   logic [POWER_W-1:0]   csr_write_data;

   asp_req_if req_bus ();
   asp_rsp_if rsp_bus ();

   // Bench copy of the learned powers and the tolerance.
   logic [POWER_W-1:0]   appliance_power [POWER_REGS];
   logic [POWER_W-1:0]   tolerance;

   match_result_type     expected_matches [$];

   logic                 steady_traffic;
   logic                 hold_request;
   int                   hold_left;
   int                   idle_cycles;
   int                   error_count;
   int                   measurements_sent;
   int                   results_checked;
   int                   matches_found;
   int                   settings_applied;

   appliance_subset_power_match #(
      .NUM_APPLIANCES(NUM_APPLIANCES)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   // Search every on/off combination from all off upward and return the first
   // one whose power sum lies strictly within the tolerance of the measurement.
   function automatic match_result_type predict_match(input logic [MEAS_W-1:0] meas);
      match_result_type outcome;
      logic [SUM_W:0]   total;
      logic [SUM_W:0]   gap;
      outcome = '0;
      for (int combo = 0; combo < (1 << NUM_APPLIANCES); combo++) begin
         total = '0;
         for (int k = 0; k < NUM_APPLIANCES; k++) begin
            if (combo[k] && k < POWER_REGS) total += (SUM_W + 1)'(appliance_power[k]);
         end
         gap = (total >= (SUM_W + 1)'(meas)) ? total - (SUM_W + 1)'(meas)
                                              : (SUM_W + 1)'(meas) - total;
         if (gap < (SUM_W + 1)'(tolerance)) begin
            outcome.on_mask = combo[MASK_W-1:0];
            outcome.found   = 1'b1;
            return outcome;
         end
      end
      return outcome;
   endfunction

   // Mostly measurements close to the sum of a random combination, so that the
   // search ends at varied depths; the rest spans the whole field.
   function automatic logic [MEAS_W-1:0] next_measurement();
      logic [MASK_W-1:0] pick;
      int                total;
      int                spread;
      int                value;
      if ($urandom_range(99, 0) >= 65) return MEAS_W'($urandom_range(MEAS_MAX, 0));
      pick  = MASK_W'($urandom_range((1 << MASK_W) - 1, 0));
      total = 0;
      for (int k = 0; k < POWER_REGS; k++) begin
         if (pick[k]) total += int'(appliance_power[k]);
      end
      spread = int'(tolerance) + int'(tolerance) / 2 + 2;
      value  = total + int'($urandom_range(2 * spread, 0)) - spread;
      if (value < 0) value = 0;
      if (value > MEAS_MAX) value = MEAS_MAX;
      return MEAS_W'(value);
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   // Offer one measurement and hold it until the block takes the beat.
   task automatic send_measurement(input logic [MEAS_W-1:0] meas);
      while (!steady_traffic && $urandom_range(99, 0) < 8) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.measured_power <= meas;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stop offering and wait for every outstanding result.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
   endtask

   // Write all eight registers from the bench copy; the block must be idle.
   task automatic commit_settings();
      for (int k = 0; k < POWER_REGS; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= k[IDX_W-1:0];
         csr_write_data   <= appliance_power[k];
         @(posedge clock);
      end
      csr_write_enable <= 1'b1;
      csr_index        <= asp_pkg::REG_TOLERANCE;
      csr_write_data   <= tolerance;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic choose_settings(input settings_style_type style);
      int base;
      base = $urandom_range(4000, 1);
      for (int k = 0; k < POWER_REGS; k++) begin
         unique case (style)
            STYLE_SMALL:     appliance_power[k] = POWER_W'($urandom_range(5000, 0));
            STYLE_BINARY:    appliance_power[k] = POWER_W'(base << k);
            STYLE_SATURATED: appliance_power[k] = POWER_W'(POWER_MAX);
            STYLE_SPARSE:    appliance_power[k] = $urandom_range(1, 0) ?
                                POWER_W'($urandom_range(POWER_MAX, 0)) : '0;
            default:         appliance_power[k] = POWER_W'($urandom_range(POWER_MAX, 0));
         endcase
      end
      unique case (style)
         STYLE_WIDE:      tolerance = POWER_W'($urandom_range(20000, 0));
         STYLE_SMALL:     tolerance = POWER_W'($urandom_range(300, 1));
         STYLE_BINARY:    tolerance = POWER_W'($urandom_range(base, 1));
         STYLE_SATURATED: tolerance = POWER_W'($urandom_range(POWER_MAX, 1));
         STYLE_LOOSE:     tolerance = POWER_W'(POWER_MAX);
         default:         tolerance = POWER_W'($urandom_range(1, 0));
      endcase
   endtask

   // Register defaults: only appliance 1 has power, tolerance is 5 W.
   task automatic test_reset_values();
      send_measurement(23'd0);
      send_measurement(23'd499);
      send_measurement(23'd500);
      send_measurement(23'd21873);
      send_measurement(23'd22372);
      send_measurement(23'd22871);
      send_measurement(23'd22872);
      send_measurement(23'(MEAS_MAX));
      drain_results();
   endtask

   // Powers in binary steps make every combination sum unique, so each
   // appliance bit and the all-on mask are seen on their own.
   task automatic test_each_appliance();
      for (int k = 0; k < POWER_REGS; k++) appliance_power[k] = POWER_W'(1000 << k);
      tolerance = 20'd300;
      commit_settings();
      for (int k = 0; k < POWER_REGS; k++) send_measurement(MEAS_W'(1000 << k));
      send_measurement(23'd127000);
      send_measurement(23'd1500);
      drain_results();
   endtask

   // With zero tolerance even exact sums must not match.
   task automatic test_zero_tolerance();
      tolerance = '0;
      commit_settings();
      send_measurement(23'd0);
      send_measurement(23'd127000);
      drain_results();
   endtask

   // Largest powers and tolerance: all off, all on only, and just out of reach.
   task automatic test_field_extremes();
      for (int k = 0; k < POWER_REGS; k++) appliance_power[k] = POWER_W'(POWER_MAX);
      tolerance = POWER_W'(POWER_MAX);
      commit_settings();
      send_measurement(23'd0);
      send_measurement(23'd8388599);
      send_measurement(23'(MEAS_MAX));
      drain_results();
   endtask

   // Receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_stall();
      choose_settings(STYLE_SMALL);
      commit_settings();
      hold_request <= 1'b1;
      for (int n = 0; n < 10; n++) send_measurement(next_measurement());
      drain_results();
   endtask

   // Random measurements under a run of register settings, one style per phase.
   task automatic test_random_phases();
      settings_style_type plan [6];
      plan = '{STYLE_WIDE, STYLE_SMALL, STYLE_BINARY, STYLE_SATURATED, STYLE_LOOSE,
               STYLE_SPARSE};
      foreach (plan[p]) begin
         choose_settings(plan[p]);
         commit_settings();
         steady_traffic = (plan[p] == STYLE_SMALL);
         for (int n = 0; n < PHASE_BEATS; n++) send_measurement(next_measurement());
         drain_results();
         steady_traffic = 1'b0;
      end
   endtask

   // Result side: random stalls, a quiet stretch, and one long hold-off on request.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_traffic || ($urandom_range(99, 0) >= 8);
      end
   end

   // Record a prediction for every accepted measurement and check every result beat.
   always @(posedge clock) begin
      match_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (rsp_bus.found === 1'b1) matches_found++;
            if (expected_matches.size() == 0) begin
               note_failure($sformatf("result with nothing expected: on_mask=%b found=%b",
                                      rsp_bus.on_mask, rsp_bus.found));
            end else begin
               want = expected_matches.pop_front();
               if (rsp_bus.on_mask !== want.on_mask || rsp_bus.found !== want.found)
                  note_failure($sformatf(
                     "result %0d: expected on_mask=%b found=%b, got on_mask=%b found=%b",
                     results_checked, want.on_mask, want.found,
                     rsp_bus.on_mask, rsp_bus.found));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            measurements_sent++;
            expected_matches.push_back(predict_match(req_bus.measured_power));
         end
      end
   end

   // End the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_index              = '0;
      csr_write_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.measured_power = '0;
      rsp_bus.ready          = 1'b0;
      steady_traffic         = 1'b0;
      hold_request           = 1'b0;
      hold_left              = 0;
      idle_cycles            = 0;
      error_count            = 0;
      measurements_sent      = 0;
      results_checked        = 0;
      matches_found          = 0;
      settings_applied       = 0;
      for (int k = 0; k < POWER_REGS; k++) appliance_power[k] = '0;
      appliance_power[0] = asp_pkg::APPLIANCE_1_RESET;
      tolerance          = asp_pkg::TOLERANCE_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_each_appliance();
      test_zero_tolerance();
      test_field_extremes();
      test_output_stall();
      test_random_phases();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_matches.size() != 0)
         note_failure($sformatf("%0d results never arrived", expected_matches.size()));

      $display("Searched %0d measurements under %0d register settings plus the defaults.",
               measurements_sent, settings_applied);
      $display("Checked %0d results: %0d matched a combination, %0d found none.",
               results_checked, matches_found, results_checked - matches_found);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
